// File: rtl/vertex_transform_perspective_project_assert.svh
// Assertion macros for the checker file of the vertex projector.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_PROJECT_ASSERT_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_PROJECT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define VTPP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vtpp assertion failed");

// Next-cycle implication, disabled while in reset.
`define VTPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vtpp assertion failed");

`endif

// File: rtl/vtpp_pkg.sv
// Types and constants shared by the vertex projector modules.
package vtpp_pkg;

    localparam int NROW     = 4;                 // matrix rows and vertex components
    localparam int VERT_W   = 16;                // Q3.12 vertex component
    localparam int COEF_W   = 12;                // Q1.10 coefficient
    localparam int ROW_W    = NROW * COEF_W;     // packed coefficient row
    localparam int PROD_W   = VERT_W + COEF_W;   // one Q.22 product
    localparam int T_W      = PROD_W + 2;        // sum of four products
    localparam int CAM_W    = 16;
    localparam int FOCAL_W  = 10;
    localparam int CENTRE_W = 24;
    localparam int CBYTE_W  = 8;
    localparam int CAM_SH   = 10;                // Q4.12 -> Q.22 alignment
    localparam int D_S_W    = T_W + 1;           // signed divisor before the sign test
    localparam int D_W      = 29;                // positive divisor magnitude
    localparam int DEN_W    = D_W + 1;           // doubled divisor
    localparam int P_W      = 40;                // t * focal, signed
    localparam int NUM_W    = 40;                // 2*|t*focal| + d
    localparam int Q_W      = 16;                // quotient bits before saturation
    localparam int QB_W     = $clog2(Q_W);
    localparam int CMP_W    = DEN_W + Q_W;       // divisor shifted to the top bit
    localparam int NLANE    = 3;
    localparam int VOX_W    = 16;
    localparam int R_W      = Q_W + 2;           // signed quotient plus centre

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;

    // register indices
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_W  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE = 3'd6;

    localparam logic [CAM_W-1:0]   CAM_RESET   = 16'd16384;
    localparam logic [FOCAL_W-1:0] FOCAL_RESET = 10'd64;

    // row order inside cfg_t.rows
    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_Z = 2;
    localparam int ROW_W_IDX = 3;

    // lane order: 0 -> voxel_x (w'), 1 -> voxel_y (-y'), 2 -> voxel_z (-x')
    localparam logic signed [VOX_W-1:0] VOX_MAX = 16'sh7FFF;
    localparam logic signed [VOX_W-1:0] VOX_MIN = -16'sh8000;

    typedef struct packed {
        logic [NROW-1:0][ROW_W-1:0] rows;
        logic [CAM_W-1:0]           cam_dist;
        logic [FOCAL_W-1:0]         focal;
        logic [CENTRE_W-1:0]        centre;
    } cfg_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   quo;
        logic             neg;
        logic             sat;
    } lane_t;

    typedef struct packed {
        lane_t [NLANE-1:0] lane;
        logic [DEN_W-1:0]  den;
        logic              behind;
    } dv_t;

endpackage

// File: rtl/vtpp_matmul.sv
// Matrix-vector multiply: product stage then row-sum stage.
module vtpp_matmul (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  vtpp_pkg::cfg_t                             cfg,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [vtpp_pkg::NROW-1:0][vtpp_pkg::VERT_W-1:0] vert,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [vtpp_pkg::NROW-1:0][vtpp_pkg::T_W-1:0]    t_out
);

    localparam int N = vtpp_pkg::NROW;

    logic [1:0] v_reg;
    logic [2:0] adv;

    logic signed [vtpp_pkg::PROD_W-1:0] prod_reg  [N][N];
    logic signed [vtpp_pkg::PROD_W-1:0] prod_next [N][N];
    logic [N-1:0][vtpp_pkg::T_W-1:0]    t_reg;
    logic [N-1:0][vtpp_pkg::T_W-1:0]    t_next;

    assign adv[2]    = out_ready;
    assign adv[1]    = !v_reg[1] || adv[2];
    assign adv[0]    = !v_reg[0] || adv[1];
    assign in_ready  = adv[0];
    assign out_valid = v_reg[1];
    assign t_out     = t_reg;

    always_comb begin
        logic signed [vtpp_pkg::PROD_W-1:0] a;
        logic signed [vtpp_pkg::PROD_W-1:0] b;
        for (int r = 0; r < N; r++) begin
            for (int k = 0; k < N; k++) begin
                a = vtpp_pkg::PROD_W'($signed(vert[k]));
                b = vtpp_pkg::PROD_W'($signed(cfg.rows[r][k*vtpp_pkg::COEF_W +: vtpp_pkg::COEF_W]));
                prod_next[r][k] = a * b;
            end
        end
    end

    always_comb begin
        for (int r = 0; r < N; r++) begin
            t_next[r] = vtpp_pkg::T_W'(prod_reg[r][0]) + vtpp_pkg::T_W'(prod_reg[r][1])
                      + vtpp_pkg::T_W'(prod_reg[r][2]) + vtpp_pkg::T_W'(prod_reg[r][3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) prod_reg <= prod_next;
        if (adv[1]) t_reg <= t_next;
    end

endmodule

// File: rtl/vtpp_persp.sv
// Divisor and focal scaling, then numerator/denominator set-up for the divider.
module vtpp_persp (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  vtpp_pkg::cfg_t                               cfg,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [vtpp_pkg::NROW-1:0][vtpp_pkg::T_W-1:0] t_in,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output vtpp_pkg::dv_t                                dv_out
);

    localparam int NL = vtpp_pkg::NLANE;

    logic [1:0] v_reg;
    logic [2:0] adv;

    logic signed [vtpp_pkg::D_S_W-1:0] d_reg, d_next;
    logic signed [vtpp_pkg::P_W-1:0]   p_reg  [NL];
    logic signed [vtpp_pkg::P_W-1:0]   p_next [NL];
    vtpp_pkg::dv_t                      dv_reg, dv_next;

    assign adv[2]    = out_ready;
    assign adv[1]    = !v_reg[1] || adv[2];
    assign adv[0]    = !v_reg[0] || adv[1];
    assign in_ready  = adv[0];
    assign out_valid = v_reg[1];
    assign dv_out    = dv_reg;

    always_comb begin
        logic signed [vtpp_pkg::P_W-1:0]   f;
        logic [vtpp_pkg::T_W-1:0]          tsel [NL];
        logic [vtpp_pkg::CAM_W+vtpp_pkg::CAM_SH:0] cam_al;
        cam_al  = {1'b0, cfg.cam_dist, {vtpp_pkg::CAM_SH{1'b0}}};
        d_next  = vtpp_pkg::D_S_W'($signed(t_in[vtpp_pkg::ROW_Z]))
                + vtpp_pkg::D_S_W'($signed(cam_al));
        f       = vtpp_pkg::P_W'($signed({1'b0, cfg.focal}));
        tsel[0] = t_in[vtpp_pkg::ROW_W_IDX];
        tsel[1] = t_in[vtpp_pkg::ROW_Y];
        tsel[2] = t_in[vtpp_pkg::ROW_X];
        for (int l = 0; l < NL; l++) begin
            p_next[l] = vtpp_pkg::P_W'($signed(tsel[l])) * f;
        end
    end

    always_comb begin
        logic [vtpp_pkg::P_W-1:0] mag;
        logic [vtpp_pkg::D_W-1:0] d_mag;
        d_mag         = d_reg[vtpp_pkg::D_W-1:0];
        dv_next.behind = d_reg[vtpp_pkg::D_S_W-1] || (d_reg == '0);
        dv_next.den   = {d_mag, 1'b0};
        for (int l = 0; l < NL; l++) begin
            mag = p_reg[l][vtpp_pkg::P_W-1] ? vtpp_pkg::P_W'(-p_reg[l])
                                             : vtpp_pkg::P_W'(p_reg[l]);
            dv_next.lane[l].rem = {mag[vtpp_pkg::NUM_W-2:0], 1'b0}
                                + vtpp_pkg::NUM_W'(d_mag);
            dv_next.lane[l].quo = '0;
            dv_next.lane[l].sat = 1'b0;
            // lane 0 keeps the sign of w', lanes 1 and 2 are negated
            if (l == 0) begin
                dv_next.lane[l].neg = p_reg[l][vtpp_pkg::P_W-1];
            end else begin
                dv_next.lane[l].neg = !p_reg[l][vtpp_pkg::P_W-1] && (p_reg[l] != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            d_reg <= d_next;
            p_reg <= p_next;
        end
        if (adv[1]) dv_reg <= dv_next;
    end

endmodule

// File: rtl/vtpp_divider.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit a stage.
module vtpp_divider (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  vtpp_pkg::dv_t dv_in,
    output logic          out_valid,
    input  logic          out_ready,
    output vtpp_pkg::dv_t dv_out
);

    // stage 0: overflow test, stages 1..Q_W: one quotient bit each
    localparam int NSTG = vtpp_pkg::Q_W + 1;
    localparam int NL   = vtpp_pkg::NLANE;

    logic          v_reg   [NSTG];
    vtpp_pkg::dv_t st_reg  [NSTG];
    vtpp_pkg::dv_t st_next [NSTG];
    logic [NSTG:0] adv;

    function automatic vtpp_pkg::dv_t ovf_check(input vtpp_pkg::dv_t x);
        vtpp_pkg::dv_t y;
        logic [vtpp_pkg::CMP_W-1:0] lim;
        y   = x;
        lim = {x.den, {vtpp_pkg::Q_W{1'b0}}};
        for (int l = 0; l < NL; l++) begin
            y.lane[l].sat = vtpp_pkg::CMP_W'(x.lane[l].rem) >= lim;
            y.lane[l].quo = '0;
        end
        return y;
    endfunction

    function automatic vtpp_pkg::dv_t div_step(input vtpp_pkg::dv_t x,
                                               input logic [vtpp_pkg::QB_W-1:0] sh);
        vtpp_pkg::dv_t y;
        logic [vtpp_pkg::CMP_W-1:0] sden;
        y    = x;
        sden = vtpp_pkg::CMP_W'(x.den) << sh;
        for (int l = 0; l < NL; l++) begin
            if (vtpp_pkg::CMP_W'(x.lane[l].rem) >= sden) begin
                y.lane[l].rem     = x.lane[l].rem - sden[vtpp_pkg::NUM_W-1:0];
                y.lane[l].quo[sh] = 1'b1;
            end
        end
        return y;
    endfunction

    assign adv[NSTG] = out_ready;
    assign in_ready  = adv[0];
    assign out_valid = v_reg[NSTG-1];
    assign dv_out    = st_reg[NSTG-1];

    for (genvar j = 0; j < NSTG; j++) begin : g_stage
        assign adv[j] = !v_reg[j] || adv[j+1];

        if (j == 0) begin : g_first
            always_comb st_next[j] = ovf_check(dv_in);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[j] <= 1'b0;
                end else if (adv[j]) begin
                    v_reg[j] <= in_valid;
                end
            end
        end else begin : g_bit
            always_comb st_next[j] = div_step(st_reg[j-1],
                                              vtpp_pkg::QB_W'(vtpp_pkg::Q_W - j));

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[j] <= 1'b0;
                end else if (adv[j]) begin
                    v_reg[j] <= v_reg[j-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[j]) st_reg[j] <= st_next[j];
        end
    end

endmodule

// File: rtl/vtpp_saturate.sv
// Sign, centre offset and 16-bit saturation into the output register.
module vtpp_saturate (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic [vtpp_pkg::CENTRE_W-1:0]                 centre,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  vtpp_pkg::dv_t                                 dv_in,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [vtpp_pkg::NLANE-1:0][vtpp_pkg::VOX_W-1:0] voxel,
    output logic                                          behind
);

    localparam int NL = vtpp_pkg::NLANE;

    logic v_reg;
    logic [NL-1:0][vtpp_pkg::VOX_W-1:0] vox_reg, vox_next;
    logic behind_reg, behind_next;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign voxel     = vox_reg;
    assign behind    = behind_reg;

    always_comb begin
        logic [vtpp_pkg::CBYTE_W-1:0] c;
        logic signed [vtpp_pkg::R_W-1:0] q;
        logic signed [vtpp_pkg::R_W-1:0] r;
        behind_next = dv_in.behind;
        for (int l = 0; l < NL; l++) begin
            c = centre[l*vtpp_pkg::CBYTE_W +: vtpp_pkg::CBYTE_W];
            q = $signed({2'b00, dv_in.lane[l].quo});
            r = (dv_in.lane[l].neg ? -q : q) + $signed(vtpp_pkg::R_W'(c));
            if (dv_in.behind) begin
                vox_next[l] = vtpp_pkg::VOX_W'(c);
            end else if (dv_in.lane[l].sat) begin
                vox_next[l] = dv_in.lane[l].neg ? vtpp_pkg::VOX_MIN : vtpp_pkg::VOX_MAX;
            end else if (r > vtpp_pkg::R_W'(vtpp_pkg::VOX_MAX)) begin
                vox_next[l] = vtpp_pkg::VOX_MAX;
            end else if (r < vtpp_pkg::R_W'(vtpp_pkg::VOX_MIN)) begin
                vox_next[l] = vtpp_pkg::VOX_MIN;
            end else begin
                vox_next[l] = r[vtpp_pkg::VOX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            vox_reg    <= vox_next;
            behind_reg <= behind_next;
        end
    end

endmodule

// File: rtl/vertex_transform_perspective_project.sv
// Top level of the 4x4 vertex transform and perspective projector.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: vertex_x, vertex_y, vertex_z, vertex_w
//  m_        out  m_tvalid/m_tready  m_tdata: voxel_x, voxel_y, voxel_z; m_tuser: behind_camera
//  cfg_      in   cfg_wr_en          cfg_index, cfg_wr_data (no read-back)
//
// One vertex per clock sustained while m_tready stays high. From an s_ transaction to the earliest m_
// transaction: 2 multiply/sum stages, 2 divisor/scale stages, 17 divider stages, 1 output register.
// The 16-step restoring divider sets the depth; each stage resolves one quotient bit.
// aresetn (synchronous, active low) empties the pipe and loads the register reset values.
// Each stage holds only while it is full and the stage after it is held, so bubbles
// close up under an m_ stall and s_tready stays high until the pipe is full.
module vertex_transform_perspective_project (
    input  logic        aclk,
    input  logic        aresetn,
    // input vertex stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,      // [15:0] vertex_x, [31:16] vertex_y,
                                      // [47:32] vertex_z, [63:48] vertex_w
    // projected voxel stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // [15:0] voxel_x, [31:16] voxel_y, [47:32] voxel_z
    output logic [0:0]  m_tuser,      // [0] behind_camera
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [vtpp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vtpp_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    vtpp_pkg::cfg_t cfg_reg;

    // stage-to-stage handshakes
    logic mm_valid, mm_ready;
    logic ps_valid, ps_ready;
    logic dv_valid, dv_ready;

    logic [vtpp_pkg::NROW-1:0][vtpp_pkg::VERT_W-1:0]  vert;
    logic [vtpp_pkg::NROW-1:0][vtpp_pkg::T_W-1:0]     t_vec;
    vtpp_pkg::dv_t                                     ps_dv, dv_res;
    logic [vtpp_pkg::NLANE-1:0][vtpp_pkg::VOX_W-1:0]   voxel;
    logic                                              behind;

    assign vert = s_tdata;

    // Register file. Writes must land only while the pipe is idle (the user's duty; the block
    // does not enforce it), so every stage reads the live values directly with no per-transaction copy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rows     <= '0;
            cfg_reg.cam_dist <= vtpp_pkg::CAM_RESET;
            cfg_reg.focal    <= vtpp_pkg::FOCAL_RESET;
            cfg_reg.centre   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                vtpp_pkg::REG_ROW_X:  cfg_reg.rows[vtpp_pkg::ROW_X]     <= cfg_wr_data;
                vtpp_pkg::REG_ROW_Y:  cfg_reg.rows[vtpp_pkg::ROW_Y]     <= cfg_wr_data;
                vtpp_pkg::REG_ROW_Z:  cfg_reg.rows[vtpp_pkg::ROW_Z]     <= cfg_wr_data;
                vtpp_pkg::REG_ROW_W:  cfg_reg.rows[vtpp_pkg::ROW_W_IDX] <= cfg_wr_data;
                vtpp_pkg::REG_CAMERA: cfg_reg.cam_dist <= cfg_wr_data[vtpp_pkg::CAM_W-1:0];
                vtpp_pkg::REG_FOCAL:  cfg_reg.focal    <= cfg_wr_data[vtpp_pkg::FOCAL_W-1:0];
                vtpp_pkg::REG_CENTRE: cfg_reg.centre   <= cfg_wr_data[vtpp_pkg::CENTRE_W-1:0];
                default: ;  // unused index: write dropped
            endcase
        end
    end

    // x', y', z', w' in Q.22
    vtpp_matmul u_matmul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vert      (vert),
        .out_valid (mm_valid),
        .out_ready (mm_ready),
        .t_out     (t_vec)
    );

    // d = z' + distance, numerators 2|t*focal| + d, denominator 2d
    vtpp_persp u_persp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (mm_valid),
        .in_ready  (mm_ready),
        .t_in      (t_vec),
        .out_valid (ps_valid),
        .out_ready (ps_ready),
        .dv_out    (ps_dv)
    );

    // round-to-nearest quotient via floor((2|n| + d) / 2d), saturating flag above 16 bits
    vtpp_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ps_valid),
        .in_ready  (ps_ready),
        .dv_in     (ps_dv),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .dv_out    (dv_res)
    );

    // sign, centre, clamp; behind-camera results carry the centre itself
    vtpp_saturate u_saturate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .centre    (cfg_reg.centre),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .dv_in     (dv_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .voxel     (voxel),
        .behind    (behind)
    );

    assign m_tdata    = voxel;
    assign m_tuser[0] = behind;

endmodule

// File: rtl/vtpp_checker.sv
// Port-level checker for the vertex projector, bound to the top level.
`include "vertex_transform_perspective_project_assert.svh"

module vtpp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // stalled result stays offered
    `VTPP_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // stalled result keeps its payload
    `VTPP_ASSERT_NEXT(a_m_stable, aclk, aresetn, m_tvalid && !m_tready,
                      $stable(m_tdata) && $stable(m_tuser))

    // with the sink taking, every stage advances and the input side is open
    `VTPP_ASSERT_NOW(a_ready_flow, aclk, aresetn, m_tready, s_tready)

    // behind-camera results carry the 8-bit centre, so the upper bytes are clear
    `VTPP_ASSERT_NOW(a_behind_centre, aclk, aresetn, m_tvalid && m_tuser[0],
                     (m_tdata[15:8] == 8'd0) && (m_tdata[31:24] == 8'd0) &&
                     (m_tdata[47:40] == 8'd0))

endmodule

bind vertex_transform_perspective_project vtpp_checker u_checker (.*);

// File: dv/vertex_transform_perspective_project_tb.sv
// Self-checking testbench for the vertex transform and perspective projector.
module vertex_transform_perspective_project_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Index 7 is not mapped: a write there must leave every register alone.
    localparam logic [vtpp_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int LATENCY        = 22;            // s_ transaction to earliest m_ transaction
    localparam int SETTLE_CYCLES  = 2 * LATENCY;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_VERTICES = 110;
    localparam int HOLD_AT        = 300;           // vertices in before the long stall
    localparam int HOLD_CYCLES    = 150;           // well beyond the pipe depth
    localparam int MAX_REPORTS    = 40;

    // Field order matches the s_tdata / m_tdata packing, x in the low bits.
    typedef struct packed {
        logic signed [vtpp_pkg::VERT_W-1:0] w, z, y, x;
    } vertex_t;

    typedef struct packed {
        logic                              behind;
        logic signed [vtpp_pkg::VOX_W-1:0] z, y, x;
    } voxel_t;

    // Mirror of the register file plus the queue of projected voxels still owed.
    class voxel_scoreboard;
        vtpp_pkg::cfg_t regs;
        voxel_t         expected_voxels[$];
        int             errors;

        function void load_reset();
            regs          = '0;
            regs.cam_dist = vtpp_pkg::CAM_RESET;
            regs.focal    = vtpp_pkg::FOCAL_RESET;
            errors        = 0;
        endfunction

        // Narrow registers keep their low bits only; the spare index is dropped.
        function void mirror_write(logic [vtpp_pkg::CFG_IDX_W-1:0]  idx,
                                   logic [vtpp_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                vtpp_pkg::REG_ROW_X:  regs.rows[vtpp_pkg::ROW_X]     = data;
                vtpp_pkg::REG_ROW_Y:  regs.rows[vtpp_pkg::ROW_Y]     = data;
                vtpp_pkg::REG_ROW_Z:  regs.rows[vtpp_pkg::ROW_Z]     = data;
                vtpp_pkg::REG_ROW_W:  regs.rows[vtpp_pkg::ROW_W_IDX] = data;
                vtpp_pkg::REG_CAMERA: regs.cam_dist = data[vtpp_pkg::CAM_W-1:0];
                vtpp_pkg::REG_FOCAL:  regs.focal    = data[vtpp_pkg::FOCAL_W-1:0];
                vtpp_pkg::REG_CENTRE: regs.centre   = data[vtpp_pkg::CENTRE_W-1:0];
                default: ;
            endcase
        endfunction

        // Q3.12 vertex times Q1.10 row, exact sum in Q.22.
        function longint dot_row(logic [vtpp_pkg::ROW_W-1:0] row, vertex_t v);
            logic signed [vtpp_pkg::VERT_W-1:0] comp [vtpp_pkg::NROW];
            longint acc;
            comp[0] = v.x;
            comp[1] = v.y;
            comp[2] = v.z;
            comp[3] = v.w;
            acc = 0;
            for (int k = 0; k < vtpp_pkg::NROW; k++)
                acc += longint'($signed(row[vtpp_pkg::COEF_W*k +: vtpp_pkg::COEF_W]))
                     * longint'(comp[k]);
            return acc;
        endfunction

        // round(t*focal/d), ties away from zero, quotient clamp, add centre, saturate
        function logic signed [vtpp_pkg::VOX_W-1:0] project_lane(
                longint t, longint d, logic [vtpp_pkg::CBYTE_W-1:0] c);
            longint          n, r;
            longint unsigned mag, ud, q;
            n   = t * longint'(regs.focal);
            mag = (n < 0) ? -n : n;
            ud  = d;
            q   = (2 * mag + ud) / (2 * ud);
            if (q > 64'h10_0000)
                q = 64'h10_0000;
            r = (n < 0) ? -longint'(q) : longint'(q);
            r += longint'(c);
            if (r > longint'(vtpp_pkg::VOX_MAX))
                r = vtpp_pkg::VOX_MAX;
            if (r < longint'(vtpp_pkg::VOX_MIN))
                r = vtpp_pkg::VOX_MIN;
            return r[vtpp_pkg::VOX_W-1:0];
        endfunction

        function void note_vertex(vertex_t v);
            longint tx, ty, tz, tw, d;
            voxel_t e;
            tx = dot_row(regs.rows[vtpp_pkg::ROW_X], v);
            ty = dot_row(regs.rows[vtpp_pkg::ROW_Y], v);
            tz = dot_row(regs.rows[vtpp_pkg::ROW_Z], v);
            tw = dot_row(regs.rows[vtpp_pkg::ROW_W_IDX], v);
            d  = tz + (longint'(regs.cam_dist) <<< vtpp_pkg::CAM_SH);
            if (d <= 0) begin
                // at or behind the camera plane: flag it and park on the centre
                e.behind = 1'b1;
                e.x = vtpp_pkg::VOX_W'(regs.centre[0*vtpp_pkg::CBYTE_W +: vtpp_pkg::CBYTE_W]);
                e.y = vtpp_pkg::VOX_W'(regs.centre[1*vtpp_pkg::CBYTE_W +: vtpp_pkg::CBYTE_W]);
                e.z = vtpp_pkg::VOX_W'(regs.centre[2*vtpp_pkg::CBYTE_W +: vtpp_pkg::CBYTE_W]);
            end else begin
                e.behind = 1'b0;
                e.x = project_lane(tw, d,
                                   regs.centre[0*vtpp_pkg::CBYTE_W +: vtpp_pkg::CBYTE_W]);
                e.y = project_lane(-ty, d,
                                   regs.centre[1*vtpp_pkg::CBYTE_W +: vtpp_pkg::CBYTE_W]);
                e.z = project_lane(-tx, d,
                                   regs.centre[2*vtpp_pkg::CBYTE_W +: vtpp_pkg::CBYTE_W]);
            end
            expected_voxels.push_back(e);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_voxel(voxel_t got);
            voxel_t e;
            if (expected_voxels.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: voxel with nothing expected, actual x=%0d y=%0d z=%0d b=%0b",
                             $time, got.x, got.y, got.z, got.behind);
                return;
            end
            e = expected_voxels.pop_front();
            compare_field("voxel_x", e.x, got.x);
            compare_field("voxel_y", e.y, got.y);
            compare_field("voxel_z", e.z, got.z);
            compare_field("behind_camera", e.behind, got.behind);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [63:0]                     s_tdata     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [47:0]                     m_tdata;
    logic [0:0]                      m_tuser;
    logic                            cfg_wr_en   = 1'b0;
    logic [vtpp_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [vtpp_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

    voxel_scoreboard voxel_sb;
    int accepted_vertices = 0;
    bit rx_holding        = 1'b0;  // sink is in its long stall
    bit hold_done         = 1'b0;
    bit steady_sender     = 1'b0;  // phase with no source gaps

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    vertex_transform_perspective_project dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Monitor: both channels sampled on the rising edge. Every s_ transaction
    // queues a prediction made with the mirrored registers (they only change
    // while the pipe is empty); every m_ transaction is checked against the
    // oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                voxel_sb.note_vertex(vertex_t'(s_tdata));
                accepted_vertices++;
            end
            if (m_tvalid && m_tready)
                voxel_sb.check_voxel(voxel_t'({m_tuser[0], m_tdata}));
        end
    end

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    function automatic logic [vtpp_pkg::CFG_DATA_W-1:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    // Random junk from bit w upward, so the register truncation gets exercised.
    function automatic logic [vtpp_pkg::CFG_DATA_W-1:0] junk_above(
            logic [vtpp_pkg::CFG_DATA_W-1:0] v, int w);
        logic [vtpp_pkg::CFG_DATA_W-1:0] mask;
        mask = {vtpp_pkg::CFG_DATA_W{1'b1}} << w;
        return (rand48() & mask) | (v & ~mask);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Components keep their low 16 bits.
    function automatic vertex_t make_vertex(int x, int y, int z, int w);
        vertex_t v;
        v.x = vtpp_pkg::VERT_W'(x);
        v.y = vtpp_pkg::VERT_W'(y);
        v.z = vtpp_pkg::VERT_W'(z);
        v.w = vtpp_pkg::VERT_W'(w);
        return v;
    endfunction

    // Half full range, some small magnitudes, some corner values.
    function automatic logic signed [vtpp_pkg::VERT_W-1:0] rand_comp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return vtpp_pkg::VERT_W'($urandom);
        if (r < 80)
            return vtpp_pkg::VERT_W'($urandom_range(0, 16384) - 8192);
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic vertex_t rand_vertex();
        return make_vertex(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endfunction

    // Coefficients: mostly random, some -2.0, max, zero, +1.0, -1.0.
    function automatic logic [vtpp_pkg::ROW_W-1:0] rand_row();
        logic [vtpp_pkg::ROW_W-1:0]  row;
        logic [vtpp_pkg::COEF_W-1:0] picks [5] = '{12'h800, 12'h7FF, 12'h000, 12'h400, 12'hC00};
        for (int k = 0; k < vtpp_pkg::NROW; k++) begin
            if ($urandom_range(0, 99) < 30)
                row[vtpp_pkg::COEF_W*k +: vtpp_pkg::COEF_W] = picks[$urandom_range(0, 4)];
            else
                row[vtpp_pkg::COEF_W*k +: vtpp_pkg::COEF_W] = vtpp_pkg::COEF_W'($urandom);
        end
        return row;
    endfunction

    // First random phase takes every register at its minimum, the last at its maximum.
    function automatic vtpp_pkg::cfg_t rand_cfg(int p);
        vtpp_pkg::cfg_t c;
        int             r;
        if (p == 0) begin
            c.rows     = {(vtpp_pkg::NROW * vtpp_pkg::NROW){12'h800}};
            c.cam_dist = '0;
            c.focal    = '0;
            c.centre   = '0;
        end else if (p == RANDOM_PHASES - 1) begin
            c.rows     = {(vtpp_pkg::NROW * vtpp_pkg::NROW){12'h7FF}};
            c.cam_dist = '1;
            c.focal    = '1;
            c.centre   = '1;
        end else begin
            for (int k = 0; k < vtpp_pkg::NROW; k++)
                c.rows[k] = rand_row();
            r = $urandom_range(0, 9);
            c.cam_dist = (r < 2) ? '0 : (r < 4) ? '1 : (r < 6) ? vtpp_pkg::CAM_RESET
                                                               : vtpp_pkg::CAM_W'($urandom);
            r = $urandom_range(0, 9);
            c.focal    = (r < 2) ? '0 : (r < 4) ? '1 : vtpp_pkg::FOCAL_W'($urandom);
            r = $urandom_range(0, 9);
            c.centre   = (r < 2) ? '0 : (r < 4) ? '1 : vtpp_pkg::CENTRE_W'($urandom);
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Drive tasks: everything changes on the falling edge
    // ------------------------------------------------------------------
    // Leaves cfg_wr_en high; program_regs drops it once after the last write
    // so back-to-back writes never assign it twice in one step.
    task automatic cfg_write(input logic [vtpp_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [vtpp_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        voxel_sb.mirror_write(idx, data);
        @(negedge aclk);
    endtask

    task automatic program_regs(input vtpp_pkg::cfg_t c);
        cfg_write(vtpp_pkg::REG_ROW_X,  c.rows[vtpp_pkg::ROW_X]);
        cfg_write(vtpp_pkg::REG_ROW_Y,  c.rows[vtpp_pkg::ROW_Y]);
        cfg_write(vtpp_pkg::REG_ROW_Z,  c.rows[vtpp_pkg::ROW_Z]);
        cfg_write(vtpp_pkg::REG_ROW_W,  c.rows[vtpp_pkg::ROW_W_IDX]);
        cfg_write(vtpp_pkg::REG_CAMERA,
                  junk_above(vtpp_pkg::CFG_DATA_W'(c.cam_dist), vtpp_pkg::CAM_W));
        cfg_write(vtpp_pkg::REG_FOCAL,
                  junk_above(vtpp_pkg::CFG_DATA_W'(c.focal), vtpp_pkg::FOCAL_W));
        cfg_write(vtpp_pkg::REG_CENTRE,
                  junk_above(vtpp_pkg::CFG_DATA_W'(c.centre), vtpp_pkg::CENTRE_W));
        cfg_write(REG_SPARE, rand48());
        cfg_wr_en <= 1'b0;
    endtask

    // One s_ transaction, then an optional idle gap. tvalid stays high across
    // back-to-back vertices; the gap is skipped while the sink is in its long
    // stall so the pipe fills and s_tready drops.
    task automatic send_vertex(input vertex_t v);
        int gap;
        s_tdata  <= v;
        s_tvalid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
        gap = (rx_holding || steady_sender) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Wait for every owed voxel, then let the pipe settle before any write.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (voxel_sb.expected_voxels.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Sink: random m_tready with steady bursts, short and long stalls, and
    // one long hold-off once enough vertices have gone in.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int r;
        int steady;
        steady = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && accepted_vertices >= HOLD_AT) begin
                rx_holding = 1'b1;
                m_tready  <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                rx_holding = 1'b0;
                hold_done  = 1'b1;
            end else if (steady > 0) begin
                steady--;
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    steady    = $urandom_range(20, 80);
                    m_tready <= 1'b1;
                end else if (r < 8) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(negedge aclk);
                end else begin
                    m_tready <= (r < 70);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        vtpp_pkg::cfg_t c;
        voxel_sb = new;
        voxel_sb.load_reset();

        // reset held from the start, released on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset values: zero matrix, so every voxel lands on the zero centre.
        send_vertex(make_vertex(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_vertex(make_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_vertex(make_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        drain();

        // Identity matrix, camera at 4.0, focal 1: d = 2^24 for z = 0, so
        // w = 8192 is exactly half a voxel - tie cases and the divisor edge.
        c                           = '0;
        c.rows[vtpp_pkg::ROW_X]     = 48'h000_000_000_400;
        c.rows[vtpp_pkg::ROW_Y]     = 48'h000_000_400_000;
        c.rows[vtpp_pkg::ROW_Z]     = 48'h000_400_000_000;
        c.rows[vtpp_pkg::ROW_W_IDX] = 48'h400_000_000_000;
        c.cam_dist                  = vtpp_pkg::CAM_RESET;
        c.focal                     = 10'd1;
        c.centre                    = 24'h30_20_10;
        program_regs(c);
        send_vertex(make_vertex(0, 0, 0, 8192));         // +0.5 rounds up
        send_vertex(make_vertex(0, 0, 0, -8192));        // -0.5 rounds away from zero
        send_vertex(make_vertex(0, 0, 0, 24576));        // 1.5 -> 2
        send_vertex(make_vertex(0, 0, 0, 8191));         // just under the tie
        send_vertex(make_vertex(0, 8192, 0, 0));         // negated y lane tie
        send_vertex(make_vertex(-8192, 0, 0, 0));        // negated x lane tie
        send_vertex(make_vertex(0, 0, -16384, 100));     // divisor exactly zero
        send_vertex(make_vertex(0, 0, -32768, 0));       // divisor negative
        send_vertex(make_vertex(16'h7FFF, 16'h7FFF, -16383, 16'h7FFF)); // tiny divisor
        send_vertex(make_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_vertex(make_vertex(-1, -1, -1, -1));
        drain();

        // Extreme coefficients, smallest non-zero camera distance, largest focal and
        // maximum centre: drives both saturation limits.
        c.rows[vtpp_pkg::ROW_X]     = {vtpp_pkg::NROW{12'h7FF}};
        c.rows[vtpp_pkg::ROW_Y]     = {vtpp_pkg::NROW{12'h800}};
        c.rows[vtpp_pkg::ROW_Z]     = 48'h000_400_000_000;
        c.rows[vtpp_pkg::ROW_W_IDX] = {vtpp_pkg::NROW{12'h7FF}};
        c.cam_dist                  = 16'd1;
        c.focal                     = '1;
        c.centre                    = '1;
        program_regs(c);
        send_vertex(make_vertex(16'h7FFF, 16'h7FFF, 0, 16'h7FFF));
        send_vertex(make_vertex(16'h8000, 16'h8000, 0, 16'h8000));
        send_vertex(make_vertex(0, 0, -1, 0));           // divisor exactly zero
        send_vertex(make_vertex(0, 0, 0, 0));
        send_vertex(make_vertex(123, -456, 16'h7FFF, 789));
        drain();

        // Random phases, each with fresh register contents.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            program_regs(rand_cfg(p));
            steady_sender = (p % 4 == 3);
            for (int i = 0; i < PHASE_VERTICES; i++)
                send_vertex(rand_vertex());
            drain();
        end

        if (voxel_sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
